>>> rtl/odo_pkg.sv
// ---------------------------------------------------------------------------
// odo_pkg - shared types and constants for the wheel odometry block
// States, datapath operation codes, controller/datapath buses, tables.
// ---------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STEPS = 24;

  // phase lengths in cycles (multiplier bits, divider bits)
  localparam logic [6:0] LEN_TPC  = 7'd24;
  localparam logic [6:0] LEN_TPT  = 7'd28;
  localparam logic [6:0] LEN_TRIG = 7'd32;
  localparam logic [6:0] LEN_USEC = 7'd20;
  localparam logic [6:0] LEN_DIV  = 7'd72;
  localparam logic [6:0] LEN_CORD = 7'(CORDIC_STEPS);

  localparam logic [33:0] GAIN_Q30 = 34'd652032875;
  localparam logic [19:0] USEC     = 20'd1000000;

  localparam logic [23:0] TPC_RESET = 24'd148299;
  localparam logic [27:0] TPT_RESET = 28'd3616747;

  localparam logic [2:0] ADDR_TPC = 3'd0;
  localparam logic [2:0] ADDR_TPT = 3'd4;

  // atan(2^-i) in binary angle units
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_DIFF, ST_MUL_TURN, ST_HEAD, ST_MUL_DIST, ST_CORDIC,
    ST_MUL_X, ST_ACC_X, ST_VMUL_X, ST_DIV_X,
    ST_MUL_Y, ST_ACC_Y, ST_VMUL_Y, ST_DIV_Y,
    ST_MUL_RATE, ST_DIV_RATE, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_MUL_DIFF, OP_MUL_TURN, OP_HEAD, OP_MUL_DIST, OP_CORDIC,
    OP_MUL_X, OP_ACC_X, OP_VMUL, OP_DIV_X, OP_MUL_Y, OP_ACC_Y, OP_DIV_Y,
    OP_MUL_RATE, OP_DIV_RATE
  } op_t;

  typedef struct packed {
    logic       load;
    op_t        op;
    logic [6:0] cnt;
    logic       last;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic go;
  } sts_t;

  // sign plus magnitude to saturated 32 bit two's complement
  function automatic logic [31:0] sat_out(input logic neg, input logic [31:0] mag);
    logic [31:0] m;
    if (neg) begin
      m = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
      sat_out = 32'(-m);
    end else begin
      sat_out = (mag > 32'h7fff_ffff) ? 32'h7fff_ffff : mag;
    end
  endfunction

endpackage

>>> rtl/odo_regs.sv
// ---------------------------------------------------------------------------
// odo_regs - configuration registers
// APB-style write/read of the two scale factors.
// ---------------------------------------------------------------------------
module odo_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [23:0] tpc,
  output logic [27:0] tpt
);
  import odo_pkg::*;

  logic [23:0] tpc_r;
  logic [27:0] tpt_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // decode on bit 2 only: register index is paddr/4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpc_r <= TPC_RESET;
      tpt_r <= TPT_RESET;
    end else if (wr) begin
      if (cfg_paddr[2] == ADDR_TPT[2]) begin
        tpt_r <= cfg_pwdata[27:0];
      end else begin
        tpc_r <= cfg_pwdata[23:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ADDR_TPT[2]) ? {4'b0, tpt_r} : {8'b0, tpc_r};
  assign tpc = tpc_r;
  assign tpt = tpt_r;
endmodule

>>> rtl/odo_ctrl.sv
// ---------------------------------------------------------------------------
// odo_ctrl - sequencer for the odometry datapath
// Walks the multiply, CORDIC and divide phases and owns the stream handshake.
// ---------------------------------------------------------------------------
module odo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  odo_pkg::sts_t sts,
  output odo_pkg::cmd_t cmd
);
  import odo_pkg::*;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] len;
  logic       last;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (state_r)
      ST_MUL_DIFF, ST_MUL_DIST:        len = LEN_TPC;
      ST_MUL_TURN:                     len = LEN_TPT;
      ST_CORDIC:                       len = LEN_CORD;
      ST_MUL_X, ST_MUL_Y:              len = LEN_TRIG;
      ST_VMUL_X, ST_VMUL_Y, ST_MUL_RATE: len = LEN_USEC;
      ST_DIV_X, ST_DIV_Y, ST_DIV_RATE: len = LEN_DIV;
      default:                         len = 7'd1;
    endcase
  end

  assign last = (cnt_r == len - 7'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid && sts.go) state_nxt = ST_MUL_DIFF;
      ST_MUL_DIFF: if (last) state_nxt = ST_MUL_TURN;
      ST_MUL_TURN: if (last) state_nxt = ST_HEAD;
      ST_HEAD:     state_nxt = ST_MUL_DIST;
      ST_MUL_DIST: if (last) state_nxt = ST_CORDIC;
      ST_CORDIC:   if (last) state_nxt = ST_MUL_X;
      ST_MUL_X:    if (last) state_nxt = ST_ACC_X;
      ST_ACC_X:    state_nxt = ST_VMUL_X;
      ST_VMUL_X:   if (last) state_nxt = ST_DIV_X;
      ST_DIV_X:    if (last) state_nxt = ST_MUL_Y;
      ST_MUL_Y:    if (last) state_nxt = ST_ACC_Y;
      ST_ACC_Y:    state_nxt = ST_VMUL_Y;
      ST_VMUL_Y:   if (last) state_nxt = ST_DIV_Y;
      ST_DIV_Y:    if (last) state_nxt = ST_MUL_RATE;
      ST_MUL_RATE: if (last) state_nxt = ST_DIV_RATE;
      ST_DIV_RATE: if (last) state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? 7'd0 : cnt_r + 7'd1;
  end

  // outputs
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.cnt      = cnt_r;
    cmd.last     = last;
    cmd.out_load = (state_r == ST_OUT) && out_free;
    unique case (state_r)
      ST_MUL_DIFF:          cmd.op = OP_MUL_DIFF;
      ST_MUL_TURN:          cmd.op = OP_MUL_TURN;
      ST_HEAD:              cmd.op = OP_HEAD;
      ST_MUL_DIST:          cmd.op = OP_MUL_DIST;
      ST_CORDIC:            cmd.op = OP_CORDIC;
      ST_MUL_X:             cmd.op = OP_MUL_X;
      ST_ACC_X:             cmd.op = OP_ACC_X;
      ST_VMUL_X, ST_VMUL_Y: cmd.op = OP_VMUL;
      ST_DIV_X:             cmd.op = OP_DIV_X;
      ST_MUL_Y:             cmd.op = OP_MUL_Y;
      ST_ACC_Y:             cmd.op = OP_ACC_Y;
      ST_DIV_Y:             cmd.op = OP_DIV_Y;
      ST_MUL_RATE:          cmd.op = OP_MUL_RATE;
      ST_DIV_RATE:          cmd.op = OP_DIV_RATE;
      default:              cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

>>> rtl/odo_dp.sv
// ---------------------------------------------------------------------------
// odo_dp - odometry datapath
// Shared shift-add multiplier, restoring divider, CORDIC rotator, pose state.
// ---------------------------------------------------------------------------
module odo_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  odo_pkg::cmd_t cmd,
  output odo_pkg::sts_t sts,
  input  logic [31:0]   count_left_rear,
  input  logic [31:0]   count_right_rear,
  input  logic [31:0]   count_left_front,
  input  logic [31:0]   count_right_front,
  input  logic [47:0]   stamp_us,
  input  logic [23:0]   tpc,
  input  logic [27:0]   tpt,
  output logic [31:0]   pos_x,
  output logic [31:0]   pos_y,
  output logic [31:0]   heading,
  output logic [31:0]   vel_x,
  output logic [31:0]   vel_y,
  output logic [31:0]   turn_rate
);
  import odo_pkg::*;

  // history and pose (control state)
  logic               have_prev_r;
  logic signed [32:0] prev_l_r, prev_r_r;
  logic [47:0]        prev_stamp_r;
  logic signed [47:0] acc_x_r, acc_y_r;
  logic [31:0]        heading_r;

  // per-sample working registers
  logic signed [34:0] diff_r, sum_r;
  logic [47:0]        dt_r;
  logic [63:0]        p1_r;
  logic [31:0]        dth_r;
  logic [57:0]        dmag_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic [50:0]        mag_r;
  logic               neg_r;
  logic [71:0]        nvel_r;
  logic [95:0]        acc_r;
  logic [47:0]        rem_r;
  logic [71:0]        quo_r;
  logic [31:0]        vx_r, vy_r, rate_r;
  logic [31:0]        o_px_r, o_py_r, o_hd_r, o_vx_r, o_vy_r, o_tr_r;

  // sample front end
  logic signed [32:0] ls, rs;
  logic signed [33:0] dl, dr;
  assign ls = {count_left_rear[31], count_left_rear} + {count_left_front[31], count_left_front};
  assign rs = {count_right_rear[31], count_right_rear}
            + {count_right_front[31], count_right_front};
  assign dl = {ls[32], ls} - {prev_l_r[32], prev_l_r};
  assign dr = {rs[32], rs} - {prev_r_r[32], prev_r_r};
  assign sts.go = have_prev_r && (stamp_us > prev_stamp_r);

  // trig terms after the half-turn fold
  logic signed [33:0] cx, sy, cabs, sabs;
  logic [34:0]        abs_sum;
  logic [31:0]        tmag;
  assign cx      = flip_r ? -x_r : x_r;
  assign sy      = flip_r ? -y_r : y_r;
  assign cabs    = cx[33] ? -cx : cx;
  assign sabs    = sy[33] ? -sy : sy;
  assign abs_sum = sum_r[34] ? 35'(-sum_r) : 35'(sum_r);
  assign tmag    = dth_r[31] ? 32'(-dth_r) : dth_r;

  // shared multiplier, b left aligned and scanned MSB first
  logic [63:0] a_sel;
  logic [31:0] b_sel;
  logic        is_mul;
  always_comb begin
    is_mul = 1'b1;
    unique case (cmd.op)
      OP_MUL_DIFF: begin a_sel = 64'(diff_r); b_sel = {tpc, 8'b0}; end
      OP_MUL_TURN: begin a_sel = p1_r; b_sel = {tpt, 4'b0}; end
      OP_MUL_DIST: begin a_sel = 64'(abs_sum); b_sel = {tpc, 8'b0}; end
      OP_MUL_X:    begin a_sel = 64'(dmag_r); b_sel = cabs[31:0]; end
      OP_MUL_Y:    begin a_sel = 64'(dmag_r); b_sel = sabs[31:0]; end
      OP_VMUL:     begin a_sel = 64'(mag_r); b_sel = {USEC, 12'b0}; end
      OP_MUL_RATE: begin a_sel = 64'(tmag); b_sel = {USEC, 12'b0}; end
      default:     begin a_sel = 64'd0; b_sel = 32'd0; is_mul = 1'b0; end
    endcase
  end

  logic        bbit;
  logic [95:0] acc_base, acc_nxt, rnd;
  assign bbit     = b_sel[~cmd.cnt[4:0]];
  assign acc_base = (cmd.cnt == 7'd0) ? 96'd0 : acc_r;
  assign acc_nxt  = {acc_base[94:0], 1'b0} + (bbit ? {32'd0, a_sel} : 96'd0);
  assign rnd      = acc_nxt + (96'd1 << 39);

  logic [63:0] dth_sum;
  assign dth_sum = acc_nxt[63:0] + 64'h1_0000;

  // restoring divider by dt, numerator MSB first
  logic        nbit, ge;
  logic [47:0] rem_base, rem_nxt;
  logic [48:0] r_sh;
  logic [71:0] quo_nxt;
  assign nbit     = nvel_r[7'd71 - cmd.cnt];
  assign rem_base = (cmd.cnt == 7'd0) ? 48'd0 : rem_r;
  assign r_sh     = {rem_base, nbit};
  assign ge       = r_sh >= {1'b0, dt_r};
  assign rem_nxt  = ge ? 48'(r_sh - {1'b0, dt_r}) : r_sh[47:0];
  assign quo_nxt  = {((cmd.cnt == 7'd0) ? 71'd0 : quo_r[70:0]), ge};

  logic [31:0] vmag, qrate;
  logic [47:0] qcap;
  assign vmag  = (quo_nxt > 72'h8000_0000) ? 32'h8000_0000 : quo_nxt[31:0];
  assign qcap  = (quo_nxt > 72'h8000_0000_0000) ? 48'h8000_0000_0000 : quo_nxt[47:0];
  assign qrate = qcap[47:16];

  // heading update and CORDIC set-up
  logic [31:0] head_nxt, ang;
  logic        fold;
  assign head_nxt = heading_r + dth_r;
  assign fold     = head_nxt[31] ^ head_nxt[30];
  assign ang      = {head_nxt[31] ^ fold, head_nxt[30:0]};

  // CORDIC micro-rotation
  logic signed [33:0] xs, ys, at;
  assign xs = x_r >>> cmd.cnt[4:0];
  assign ys = y_r >>> cmd.cnt[4:0];
  assign at = signed'({2'b00, ATAN_TAB[cmd.cnt[4:0]]});

  // saturating pose accumulate
  logic signed [51:0] inc;
  logic signed [52:0] accs;
  logic signed [47:0] acc_sel, acc_sat;
  assign inc     = neg_r ? -signed'({1'b0, mag_r}) : signed'({1'b0, mag_r});
  assign acc_sel = (cmd.op == OP_ACC_Y) ? acc_y_r : acc_x_r;
  assign accs    = 53'(acc_sel) + 53'(inc);
  always_comb begin
    if (accs > 53'sh7fff_ffff_ffff)       acc_sat = 48'sh7fff_ffff_ffff;
    else if (accs < -53'sh8000_0000_0000) acc_sat = 48'sh8000_0000_0000;
    else                                  acc_sat = accs[47:0];
  end

  function automatic logic [31:0] pos_clip(input logic signed [47:0] v);
    if (v > 48'sh7fff_ffff)       pos_clip = 32'h7fff_ffff;
    else if (v < -48'sh8000_0000) pos_clip = 32'h8000_0000;
    else                          pos_clip = v[31:0];
  endfunction

  // control state: history flag and pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      heading_r   <= '0;
    end else begin
      if (cmd.load) have_prev_r <= 1'b1;
      if (cmd.op == OP_HEAD) heading_r <= head_nxt;
      if (cmd.op == OP_ACC_X) acc_x_r <= acc_sat;
      if (cmd.op == OP_ACC_Y) acc_y_r <= acc_sat;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_l_r     <= ls;
      prev_r_r     <= rs;
      prev_stamp_r <= stamp_us;
      dt_r         <= stamp_us - prev_stamp_r;
      diff_r       <= {dr[33], dr} - {dl[33], dl};
      sum_r        <= {dl[33], dl} + {dr[33], dr};
    end
    if (is_mul) acc_r <= acc_nxt;
    if (cmd.last) begin
      unique case (cmd.op)
        OP_MUL_DIFF: p1_r <= acc_nxt[63:0];
        OP_MUL_TURN: dth_r <= dth_sum[48:17];
        OP_MUL_DIST: dmag_r <= acc_nxt[57:0];
        OP_MUL_X: begin mag_r <= rnd[90:40]; neg_r <= sum_r[34] ^ cx[33]; end
        OP_MUL_Y: begin mag_r <= rnd[90:40]; neg_r <= sum_r[34] ^ sy[33]; end
        OP_VMUL, OP_MUL_RATE: nvel_r <= acc_nxt[71:0];
        OP_DIV_X:    vx_r <= sat_out(neg_r, vmag);
        OP_DIV_Y:    vy_r <= sat_out(neg_r, vmag);
        OP_DIV_RATE: rate_r <= sat_out(dth_r[31], qrate);
        default: ;
      endcase
    end
    if (cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y || cmd.op == OP_DIV_RATE) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.op == OP_HEAD) begin
      x_r    <= GAIN_Q30;
      y_r    <= '0;
      z_r    <= 34'(signed'(ang));
      flip_r <= fold;
    end
    if (cmd.op == OP_CORDIC) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.out_load) begin
      o_px_r <= pos_clip(acc_x_r);
      o_py_r <= pos_clip(acc_y_r);
      o_hd_r <= heading_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_tr_r <= rate_r;
    end
  end

  assign pos_x     = o_px_r;
  assign pos_y     = o_py_r;
  assign heading   = o_hd_r;
  assign vel_x     = o_vx_r;
  assign vel_y     = o_vy_r;
  assign turn_rate = o_tr_r;
endmodule

>>> rtl/diff_drive_odometry.sv
// Flow: an accepted sample runs the multiplier bit passes, the CORDIC
//   rotation, three 72-bit divides and glue states before out_tvalid.
// One sample is processed at a time, on the single shared shift-add
//   multiplier and restoring divider; a dropped sample leaves it idle.
// Reset (rst_n low, synchronous): clears pose, heading and sample history,
//   drops any pending result and reloads both scale registers to defaults.
// ---------------------------------------------------------------------------
// diff_drive_odometry - differential drive wheel odometry
// Four encoder totals plus time stamp in; pose, heading and velocities out.
// ---------------------------------------------------------------------------
module diff_drive_odometry (
  input  logic         clk,
  input  logic         rst_n,
  // sample beat
  input  logic         in_tvalid,
  output logic         in_tready,
  // count_left_rear, count_right_rear, count_left_front, count_right_front,
  // stamp_us (lowest bits first)
  input  logic [175:0] in_tdata,
  // result beat
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, heading, vel_x, vel_y, turn_rate (lowest bits first)
  output logic [191:0] out_tdata,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import odo_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [23:0] tpc;
  logic [27:0] tpt;
  logic [31:0] pos_x, pos_y, heading, vel_x, vel_y, turn_rate;

  // scale factors: travel per count (0x0), turn per travel (0x4)
  odo_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .tpc, .tpt
  );

  // sequencer: accepts a beat in idle, a non-advancing stamp returns to idle
  // at once, otherwise steps through the phases and parks the result in the
  // output register so the next beat can be taken while it waits.
  odo_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd
  );

  odo_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .count_left_rear   (in_tdata[31:0]),
    .count_right_rear  (in_tdata[63:32]),
    .count_left_front  (in_tdata[95:64]),
    .count_right_front (in_tdata[127:96]),
    .stamp_us          (in_tdata[175:128]),
    .tpc, .tpt,
    .pos_x, .pos_y, .heading, .vel_x, .vel_y, .turn_rate
  );

  assign out_tdata = {turn_rate, vel_y, vel_x, heading, pos_y, pos_x};
endmodule

>>> rtl/odo_checker.sv
// ---------------------------------------------------------------------------
// odo_checker - port-level checks for diff_drive_odometry
// Result hold under stall, reset behavior, result timing vs. input side, config ready.
// ---------------------------------------------------------------------------
module odo_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [175:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata,
  input logic         cfg_pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

  // reset drops a pending result
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result is only posted while the sample side is busy
  a_post_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result posted while idle");

  // the config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("config port stalled");

endmodule

bind diff_drive_odometry odo_checker u_odo_checker (.*);

>>> verif/odometry_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odometry_checker - pose predictor and result comparator
// Watches sample, result and register beats, predicts each pose from the
// observed samples and compares every result beat field by field.
// ---------------------------------------------------------------------------
module odometry_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [175:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_pready,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output int           fail_count,
  output int           pending
);
  import odo_pkg::*;

  localparam longint GAIN      = 652032875;
  localparam longint POS_MAX   = 64'sh0000_7fff_ffff_ffff;
  localparam longint POS_MIN   = -POS_MAX - 1;
  localparam bit [127:0] MICRO = 128'd1000000;

  bit [23:0] travel_scale;
  bit [27:0] turn_scale;
  longint    last_left, last_right;
  bit [47:0] last_stamp;
  bit        seen_sample;
  longint    pose_x, pose_y;
  bit [31:0] pose_heading;

  bit [191:0] pose_queue [$];
  string      field_name [6] = '{"pos_x", "pos_y", "heading", "vel_x", "vel_y", "turn_rate"};

  assign pending = pose_queue.size();

  function automatic bit [31:0] clamp_mag(input bit neg, input bit [63:0] mag);
    bit [63:0] m;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      m = 64'd0 - m;
      return m[31:0];
    end
    m = (mag > 64'h7fff_ffff) ? 64'h7fff_ffff : mag;
    return m[31:0];
  endfunction

  function automatic bit [31:0] clamp_pos(input longint v);
    longint t;
    t = v;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic longint add_clamped(input longint acc, input longint d);
    if (d > 0 && acc > POS_MAX - d) return POS_MAX;
    if (d < 0 && acc < POS_MIN - d) return POS_MIN;
    return acc + d;
  endfunction

  // cos/sin of a binary angle, Q30, with half-turn folding
  function automatic void rotate_heading(input bit [31:0] ang, output longint c,
                                         output longint s);
    longint x, y, z, xs, ys;
    bit [31:0] a;
    bit flip;
    x = GAIN;
    y = 0;
    a = ang;
    flip = 1'b0;
    if (a >= 32'h4000_0000 && a < 32'hc000_0000) begin
      a = a + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // position increment (mm Q8) along one axis, velocity as side output
  function automatic longint axis_increment(input bit [63:0] dmag, input bit dneg,
                                            input longint trig, input bit [47:0] dt,
                                            output bit [31:0] vel);
    bit [63:0]  tm, mag;
    bit [127:0] prod, quo;
    bit         neg;
    tm   = (trig < 0) ? 64'(-trig) : 64'(trig);
    prod = {64'd0, dmag} * {64'd0, tm} + (128'd1 << 39);
    mag  = prod[103:40];
    neg  = dneg != (trig < 0);
    quo  = ({64'd0, mag} * MICRO) / {80'd0, dt};
    if (quo > 128'h8000_0000) quo = 128'h8000_0000;
    vel  = clamp_mag(neg, quo[63:0]);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // consume one sample; returns 1 with the expected result when one is due
  function automatic bit advance_pose(input bit [175:0] d, output bit [191:0] res);
    longint     ls, rs, dl, dr, sum, c, s, dx, dy;
    bit [47:0]  stamp, dt;
    bit [63:0]  diff, dth64, dmag, tmag;
    bit [127:0] quo;
    bit [31:0]  dth, vx, vy, rate;
    bit         got, dneg, tneg;
    ls    = longint'($signed(d[31:0])) + longint'($signed(d[95:64]));
    rs    = longint'($signed(d[63:32])) + longint'($signed(d[127:96]));
    stamp = d[175:128];
    got   = seen_sample && (stamp > last_stamp);
    res   = '0;
    if (got) begin
      dt    = stamp - last_stamp;
      dl    = ls - last_left;
      dr    = rs - last_right;
      diff  = dr - dl;
      dth64 = (diff * 64'(travel_scale) * 64'(turn_scale) + 64'h1_0000) >> 17;
      dth   = dth64[31:0];
      sum   = dl + dr;
      dneg  = sum < 0;
      dmag  = (dneg ? 64'(-sum) : 64'(sum)) * 64'(travel_scale);
      pose_heading = pose_heading + dth;
      rotate_heading(pose_heading, c, s);
      dx = axis_increment(dmag, dneg, c, dt, vx);
      dy = axis_increment(dmag, dneg, s, dt, vy);
      pose_x = add_clamped(pose_x, dx);
      pose_y = add_clamped(pose_y, dy);
      // turn rate reads the heading step as a signed angle
      tneg = dth[31];
      tmag = tneg ? (64'h1_0000_0000 - 64'(dth)) : 64'(dth);
      quo  = ({64'd0, tmag} * MICRO) / {80'd0, dt};
      if (quo > (128'd1 << 47)) quo = 128'd1 << 47;
      rate = clamp_mag(tneg, quo[63:0] >> 16);
      res  = {rate, vy, vx, pose_heading, clamp_pos(pose_y), clamp_pos(pose_x)};
    end
    last_left   = ls;
    last_right  = rs;
    last_stamp  = stamp;
    seen_sample = 1'b1;
    return got;
  endfunction

  always @(posedge clk) begin
    bit [191:0] want;
    if (!rst_n) begin
      travel_scale = TPC_RESET;
      turn_scale   = TPT_RESET;
      last_left    = 0;
      last_right   = 0;
      last_stamp   = '0;
      seen_sample  = 1'b0;
      pose_x       = 0;
      pose_y       = 0;
      pose_heading = '0;
      pose_queue.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_TPC) travel_scale = cfg_pwdata[23:0];
        else if (cfg_paddr == ADDR_TPT) turn_scale = cfg_pwdata[27:0];
      end
      if (in_tvalid && in_tready)
        if (advance_pose(in_tdata, want)) pose_queue.push_back(want);
      if (out_tvalid && out_tready) begin
        if (pose_queue.size() == 0) begin
          $error("result beat with no pose expected: %0h", out_tdata);
          fail_count++;
        end else begin
          want = pose_queue.pop_front();
          for (int f = 0; f < 6; f++)
            if (want[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
              $error("%s expected %0h got %0h", field_name[f], want[f*32 +: 32],
                     out_tdata[f*32 +: 32]);
              fail_count++;
            end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

>>> verif/tb_diff_drive_odometry.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_diff_drive_odometry - wheel odometry block testbench
// Drives encoder samples and scale register writes through several traffic
// phases; the checker predicts pose and velocity and flags mismatches.
// ---------------------------------------------------------------------------
module tb_diff_drive_odometry;
  import odo_pkg::*;

  localparam int IDLE_LIMIT  = 20000;  // cycles with no beat at all
  localparam int DRAIN_WAIT  = 600;    // one full processing pass plus margin
  localparam int PHASE_ITEMS = 210;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;   // count_lr, count_rr, count_lf, count_rf, stamp_us
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;
  logic         cfg_pready;

  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;
  int quiet_cycles;

  // running encoder totals and stamp of the well-formed traffic
  bit [31:0] wheel [4];
  bit [47:0] stamp_now;

  diff_drive_odometry dut (.*);

  odometry_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr,
    .cfg_pwdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall per cycle at the phase's rate
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one sample beat; returns at the edge that accepted it, valid left high
  task automatic send_sample(input bit [175:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_current;
    send_sample({stamp_now, wheel[3], wheel[2], wheel[1], wheel[0]});
  endtask

  // drop valid and wait until every pose is back, then out-wait any dropped sample
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly smooth driving; the rest is stale stamps, wraps and raw noise
  task automatic random_sample;
    int kind, base;
    kind = $urandom_range(99);
    if (kind < 75) begin
      base = $urandom_range(600) - 300;
      stamp_now += ($urandom_range(9) == 0) ? 48'($urandom_range(3) + 1)
                                            : 48'($urandom_range(200000) + 1);
      wheel[0] += 32'(base + $urandom_range(40) - 20);
      wheel[2] += 32'(base + $urandom_range(40) - 20);
      base = base + $urandom_range(400) - 200;  // side difference turns
      wheel[1] += 32'(base + $urandom_range(40) - 20);
      wheel[3] += 32'(base + $urandom_range(40) - 20);
    end else if (kind < 85) begin
      stamp_now -= 48'($urandom_range(1000));  // equal or earlier stamp
    end else if (kind < 93) begin
      wheel[$urandom_range(3)] = $urandom;
      stamp_now += 48'($urandom_range(100000) + 1);
    end else begin
      for (int w = 0; w < 4; w++) wheel[w] = $urandom;
      stamp_now = {16'($urandom), 32'($urandom)};
    end
    send_current();
  endtask

  // extremes and special cases under the default scales
  task automatic directed_samples;
    wheel = '{default: 32'd0};
    stamp_now = 48'd1000;
    send_current();                          // first sample only stored
    send_current();                          // same stamp: no result
    stamp_now = 48'd500;  send_current();    // earlier stamp: no result
    stamp_now = 48'd20500;
    wheel = '{32'd100, 32'd100, 32'd100, 32'd100};
    send_current();                          // straight ahead
    stamp_now += 48'd1;
    wheel = '{32'd90, 32'd300, 32'd90, 32'd300};
    send_current();                          // turn, one microsecond step
    stamp_now += 48'd50000;
    wheel = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_current();                          // largest positive totals
    stamp_now += 48'd50000;
    wheel = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_current();                          // wrap: huge backward jump
    stamp_now += 48'd10;
    wheel = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_current();                          // largest side difference
    stamp_now += 48'd10;
    wheel = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_current();
    stamp_now = 48'hffff_ffff_ffff;
    wheel = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_current();                          // top stamp
    stamp_now = 48'd0;    send_current();    // stamp back to zero: dropped
    stamp_now = 48'd5;
    wheel = '{32'd0, 32'd5000, 32'd0, 32'd5000};
    send_current();                          // right side only: pivot turn
    stamp_now += 48'd3;
    wheel = '{32'hfff0_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0010_0000};
    send_current();                          // near half-turn step
    stamp_now += 48'hffff_0000;
    wheel = '{32'd0, 32'd0, 32'd0, 32'd0};
    send_current();                          // long time step
  endtask

  initial begin
    bit [31:0] tpc_set [8];
    bit [31:0] tpt_set [8];
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    stamp_now      = '0;
    wheel          = '{default: 32'd0};

    // scale pairs per phase: defaults, extremes, zero, one, random, powers of two
    tpc_set = '{TPC_RESET, 32'hff_ffff, 32'd0, 32'd1, 32'hff_ffff, TPC_RESET,
                $urandom & 32'hff_ffff, 32'd65536};
    tpt_set = '{TPT_RESET, 32'hfff_ffff, 32'd0, 32'hfff_ffff, 32'd1, TPT_RESET,
                $urandom & 32'hfff_ffff, 32'd1 << 20};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_samples();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(ADDR_TPC, tpc_set[ph] | ($urandom & 32'hff00_0000));
      reg_write(ADDR_TPT, tpt_set[ph] | ($urandom & 32'hf000_0000));
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 84; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 84; end
        default: begin send_idle_pct <= 26; recv_stall_pct <= 26; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_sample();
        // hold off once until the block has caught up completely
        if (ph == 0 && n == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
